// ----- hw/rtl/twed_pkg.sv -----
package twed_pkg;

   localparam int unsigned MAX_LEN_DEFAULT     = 65536;
   localparam int unsigned SAMPLE_BITS_DEFAULT = 16;

   localparam int unsigned SUM_BITS       = 56;
   localparam int unsigned HALF_BITS      = SUM_BITS / 2;
   localparam int unsigned ROOT_STEPS     = SUM_BITS / 2;
   localparam int unsigned STEP_BITS      = $clog2(SUM_BITS);
   localparam int unsigned GAIN_BITS      = 16;
   localparam int unsigned GAIN_FRAC      = 12;
   localparam int unsigned DIST_BITS      = 18;
   localparam int unsigned COUNT_OUT_BITS = 17;

   // 1.1 in Q4.12, rounded.
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4506;

   typedef enum logic [1:0] {
      SIGN_NONE = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd2
   } sign_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_GAIN_LO,
      ST_GAIN_HI,
      ST_COMBINE,
      ST_ACCUM,
      ST_DIV,
      ST_SQRT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic square;
      logic gain_lo;
      logic gain_hi;
      logic combine;
      logic accum;
      logic div_step;
      logic sqrt_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic flip;
      logic last;
   } status_type;

endpackage

// ----- hw/rtl/twed_if.sv -----
interface twed_req_if #(
   parameter int unsigned SAMPLE_BITS = twed_pkg::SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] x_sample;
   logic signed [SAMPLE_BITS-1:0] y_sample;
   logic                          last;

   modport source (output valid, output x_sample, output y_sample, output last, input ready);
   modport sink   (input valid, input x_sample, input y_sample, input last, output ready);
endinterface

interface twed_rsp_if;
   import twed_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [DIST_BITS-1:0]      distance;
   logic [COUNT_OUT_BITS-1:0] sample_count;
   logic                      saturated;

   modport source (output valid, output distance, output sample_count, output saturated,
                   input ready);
   modport sink   (input valid, input distance, input sample_count, input saturated,
                   output ready);
endinterface

// ----- hw/rtl/trend_weighted_euclid_distance.sv -----
// Trend-weighted Euclidean distance between two equal-length sample series. Each request
// carries one pair (x_sample, y_sample) and a last flag that closes the series. The block
// sums the squared differences; when the sign of x - y flips against the last nonzero sign
// of the series, the square is first scaled by the Q4.12 gain in the configuration register
// (reset value 1.1). The last request of a series produces one response with the floor of
// the square root of the floor of the mean, the pair count and a flag that tells whether the
// sum, a gain-scaled square or the count saturated; the series state then clears for the next
// series. Requests are handled one at a time: one without a trend flip is accepted, squared and
// accumulated; one with a flip is scaled first, because the 56-bit by 16-bit gain product goes
// through one 28 x 16 multiplier in two halves and is then combined. A last request adds a
// restoring division, one quotient bit per cycle, a square root, one result bit per cycle, and
// a load of the response register. The response sits in its own register, so a new request is
// accepted while a finished response waits to be taken; only the next last request waits for
// that register to empty. The user must write the gain through csr_write_enable and
// csr_write_data only while no request is in progress; the block does not enforce it.
module trend_weighted_euclid_distance #(
   parameter int unsigned MAX_LEN     = twed_pkg::MAX_LEN_DEFAULT,
   parameter int unsigned SAMPLE_BITS = twed_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   twed_req_if.sink                        req_port,
   twed_rsp_if.source                      rsp_port,
   input  logic                            csr_write_enable,
   input  logic [twed_pkg::GAIN_BITS-1:0]  csr_write_data
);
   import twed_pkg::*;

   // Commands from the controller to the datapath, status back.
   cmd_type    cmd;
   status_type status;

   twed_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the series state, the working registers and the response register.
   twed_datapath #(
      .MAX_LEN     (MAX_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .x_sample         (req_port.x_sample),
      .y_sample         (req_port.y_sample),
      .last             (req_port.last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .distance         (rsp_port.distance),
      .sample_count     (rsp_port.sample_count),
      .saturated        (rsp_port.saturated)
   );

endmodule

// ----- hw/rtl/twed_datapath.sv -----
module twed_datapath #(
   parameter int unsigned MAX_LEN     = twed_pkg::MAX_LEN_DEFAULT,
   parameter int unsigned SAMPLE_BITS = twed_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  twed_pkg::cmd_type                    cmd,
   output twed_pkg::status_type                 status,
   input  logic signed [SAMPLE_BITS-1:0]        x_sample,
   input  logic signed [SAMPLE_BITS-1:0]        y_sample,
   input  logic                                 last,
   input  logic                                 csr_write_enable,
   input  logic [twed_pkg::GAIN_BITS-1:0]       csr_write_data,
   output logic [twed_pkg::DIST_BITS-1:0]       distance,
   output logic [twed_pkg::COUNT_OUT_BITS-1:0]  sample_count,
   output logic                                 saturated
);
   import twed_pkg::*;

   localparam int unsigned MAGW  = SAMPLE_BITS + 1;
   localparam int unsigned PRODW = 2 * MAGW;
   localparam int unsigned SQW   = (PRODW > SUM_BITS) ? PRODW : SUM_BITS + 1;
   localparam int unsigned CW    = $clog2(MAX_LEN + 1);
   localparam int unsigned CXW   = (CW > COUNT_OUT_BITS) ? CW : COUNT_OUT_BITS;
   localparam int unsigned PPW   = HALF_BITS + GAIN_BITS;
   localparam int unsigned GPW   = SUM_BITS + GAIN_BITS;
   localparam int unsigned GSW   = GPW - GAIN_FRAC;

   localparam logic [CW-1:0]        COUNT_LIMIT = CW'(MAX_LEN);
   localparam logic [SUM_BITS-1:0]  SUM_MAX     = '1;
   localparam logic [DIST_BITS-1:0] DIST_MAX    = '1;
   localparam logic [SUM_BITS-1:0]  BIT_START   = SUM_BITS'(1) << (SUM_BITS - 2);

   // Series state and gain register.
   logic [GAIN_BITS-1:0] gain_ff, gain_in;
   sign_type             last_sign_ff, last_sign_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 ovf_ff, ovf_in;

   // Per-request working registers.
   logic [MAGW-1:0]       mag_ff, mag_in;
   sign_type              sign_ff, sign_in;
   logic                  last_ff, last_in;
   logic [SUM_BITS-1:0]   sq_ff, sq_in;
   logic                  term_sat_ff, term_sat_in;
   logic [PPW-1:0]        pp_lo_ff, pp_lo_in;
   logic [PPW-1:0]        pp_hi_ff, pp_hi_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic [SUM_BITS-1:0]   root_ff, root_in;
   logic [SUM_BITS-1:0]   bit_ff, bit_in;
   logic [DIST_BITS-1:0]  dist_ff, dist_in;
   logic [COUNT_OUT_BITS-1:0] cnt_out_ff, cnt_out_in;
   logic                  sat_out_ff, sat_out_in;

   logic signed [MAGW-1:0] diff;
   logic [PRODW-1:0]       prod;
   logic [SQW-1:0]         sq_ext;
   logic                   sq_over;
   logic [HALF_BITS-1:0]   mul_a;
   logic [PPW-1:0]         pp;
   logic [GPW-1:0]         gfull;
   logic [GSW-1:0]         gshift;
   logic                   gover;
   logic [SUM_BITS:0]      acc;
   logic                   count_full;
   logic [CW:0]            trial;
   logic [CW:0]            trial_sub;
   logic                   trial_ge;
   logic [SUM_BITS:0]      root_bit;
   logic                   root_take;
   logic [CXW-1:0]         cnt_x;

   assign diff   = {x_sample[SAMPLE_BITS-1], x_sample} - {y_sample[SAMPLE_BITS-1], y_sample};
   assign prod   = PRODW'(mag_ff) * PRODW'(mag_ff);
   assign sq_ext = SQW'(prod);
   assign sq_over = |sq_ext[SQW-1:SUM_BITS];

   // One 28 x 16 multiplier serves both halves of the gain product.
   assign mul_a  = cmd.gain_hi ? sq_ff[SUM_BITS-1:HALF_BITS] : sq_ff[HALF_BITS-1:0];
   assign pp     = PPW'(mul_a) * PPW'(gain_ff);
   assign gfull  = {pp_hi_ff, HALF_BITS'(0)} + GPW'(pp_lo_ff);
   assign gshift = gfull[GPW-1:GAIN_FRAC];
   assign gover  = |gshift[GSW-1:SUM_BITS];

   assign acc        = {1'b0, sum_ff} + {1'b0, sq_ff};
   assign count_full = (count_ff >= COUNT_LIMIT);

   // Restoring division: the sum register shifts out dividend bits and takes in quotient bits.
   assign trial     = {rem_ff, sum_ff[SUM_BITS-1]};
   assign trial_sub = trial - {1'b0, count_ff};
   assign trial_ge  = (trial >= {1'b0, count_ff});

   // Bit-pair square root on the quotient left in the sum register.
   assign root_bit  = {1'b0, root_ff} + {1'b0, bit_ff};
   assign root_take = ({1'b0, sum_ff} >= root_bit);

   assign cnt_x = CXW'(count_ff);

   assign status.flip = (sign_ff != SIGN_NONE) && (last_sign_ff != SIGN_NONE) &&
                        (sign_ff != last_sign_ff);
   assign status.last = last_ff;

   always_comb begin
      gain_in      = gain_ff;
      last_sign_in = last_sign_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      mag_in       = mag_ff;
      sign_in      = sign_ff;
      last_in      = last_ff;
      sq_in        = sq_ff;
      term_sat_in  = term_sat_ff;
      pp_lo_in     = pp_lo_ff;
      pp_hi_in     = pp_hi_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      dist_in      = dist_ff;
      cnt_out_in   = cnt_out_ff;
      sat_out_in   = sat_out_ff;

      if (csr_write_enable) begin
         gain_in = csr_write_data;
      end

      if (cmd.load) begin
         last_in = last;
         if (diff == '0) begin
            sign_in = SIGN_NONE;
            mag_in  = '0;
         end else if (diff[MAGW-1]) begin
            sign_in = SIGN_NEG;
            mag_in  = MAGW'(-diff);
         end else begin
            sign_in = SIGN_POS;
            mag_in  = MAGW'(diff);
         end
      end

      if (cmd.square) begin
         sq_in       = sq_over ? SUM_MAX : sq_ext[SUM_BITS-1:0];
         term_sat_in = sq_over;
         if (sign_ff != SIGN_NONE) begin
            last_sign_in = sign_ff;
         end
      end

      if (cmd.gain_lo) begin
         pp_lo_in = pp;
      end
      if (cmd.gain_hi) begin
         pp_hi_in = pp;
      end

      if (cmd.combine) begin
         sq_in       = gover ? SUM_MAX : gshift[SUM_BITS-1:0];
         term_sat_in = term_sat_ff | gover;
      end

      if (cmd.accum) begin
         sum_in   = acc[SUM_BITS] ? SUM_MAX : acc[SUM_BITS-1:0];
         count_in = count_full ? count_ff : count_ff + CW'(1);
         ovf_in   = ovf_ff | term_sat_ff | acc[SUM_BITS] | count_full;
         rem_in   = '0;
         root_in  = '0;
         bit_in   = BIT_START;
      end

      if (cmd.div_step) begin
         sum_in = {sum_ff[SUM_BITS-2:0], trial_ge};
         rem_in = trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
      end

      if (cmd.sqrt_step) begin
         if (root_take) begin
            sum_in  = sum_ff - root_bit[SUM_BITS-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end

      if (cmd.finish) begin
         dist_in      = (|root_ff[SUM_BITS-1:DIST_BITS]) ? DIST_MAX : root_ff[DIST_BITS-1:0];
         cnt_out_in   = cnt_x[COUNT_OUT_BITS-1:0];
         sat_out_in   = ovf_ff;
         sum_in       = '0;
         count_in     = '0;
         ovf_in       = 1'b0;
         last_sign_in = SIGN_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         last_sign_ff <= SIGN_NONE;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         last_sign_ff <= last_sign_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      sign_ff     <= sign_in;
      last_ff     <= last_in;
      sq_ff       <= sq_in;
      term_sat_ff <= term_sat_in;
      pp_lo_ff    <= pp_lo_in;
      pp_hi_ff    <= pp_hi_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      dist_ff     <= dist_in;
      cnt_out_ff  <= cnt_out_in;
      sat_out_ff  <= sat_out_in;
   end

   assign distance     = dist_ff;
   assign sample_count = cnt_out_ff;
   assign saturated    = sat_out_ff;

endmodule

// ----- hw/rtl/twed_controller.sv -----
module twed_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  twed_pkg::status_type  status,
   output twed_pkg::cmd_type     cmd
);
   import twed_pkg::*;

   localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(SUM_BITS - 1);
   localparam logic [STEP_BITS-1:0] ROOT_LAST = STEP_BITS'(ROOT_STEPS - 1);

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = status.flip ? ST_GAIN_LO : ST_ACCUM;
         end
         ST_GAIN_LO: begin
            cmd.gain_lo = 1'b1;
            state_in    = ST_GAIN_HI;
         end
         ST_GAIN_HI: begin
            cmd.gain_hi = 1'b1;
            state_in    = ST_COMBINE;
         end
         ST_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            step_in   = '0;
            state_in  = status.last ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               state_in = ST_SQRT;
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == ROOT_LAST) begin
               step_in  = '0;
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_FINISH: begin
            // Wait until the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.finish;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/twed_checker.sv -----
module twed_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [twed_pkg::DIST_BITS-1:0]      rsp_distance,
   input logic [twed_pkg::COUNT_OUT_BITS-1:0] rsp_sample_count,
   input logic                                rsp_saturated
);
   import twed_pkg::*;

   // Requests are taken one at a time, so ready drops right after an accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another was in progress");

   // A response never appears in the cycle right after a request was accepted.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("response raised too soon after a request");

   // When a response appears the block is back to taking requests.
   a_idle_on_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("block not idle when its response appeared");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_distance) && $stable(rsp_sample_count) && $stable(rsp_saturated)))
      else $error("response payload changed while stalled");

endmodule

bind trend_weighted_euclid_distance twed_checker u_twed_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_port.valid),
   .req_ready        (req_port.ready),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_distance     (rsp_port.distance),
   .rsp_sample_count (rsp_port.sample_count),
   .rsp_saturated    (rsp_port.saturated)
);
